// ===== hw/rtl/tdp_pkg.sv =====
// Shared types and constants of the time-of-flight depth-to-point block.
// Depends on nothing; tdp_if, the top level and the testbench refer to it by scoped names.
package tdp_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X    = 3'd0,
      CSR_CENTER_Y    = 3'd1,
      CSR_FOCAL_X     = 3'd2,
      CSR_FOCAL_Y     = 3'd3,
      CSR_RADIAL_K1   = 3'd4,
      CSR_RADIAL_K2   = 3'd5,
      CSR_LENS_OFFSET = 3'd6
   } csr_idx_type;

   localparam logic [19:0] CENTER_X_RST = 20'd22528;
   localparam logic [19:0] CENTER_Y_RST = 20'd18432;
   localparam logic [21:0] FOCAL_X_RST  = 22'd37632;
   localparam logic [21:0] FOCAL_Y_RST  = 22'd37632;
   localparam logic [21:0] FOCAL_MIN    = 22'd256;
   localparam logic [15:0] DIST_INVALID = 16'hFFFF;

   typedef struct packed {
      logic [15:0] confidence;
      logic [15:0] intensity;
      logic [15:0] distance;
      logic        dist_ok;
   } pass_type;

   localparam int PASS_W = $bits(pass_type);

endpackage

// ===== hw/rtl/tdp_if.sv =====
// Valid/ready channel interfaces of the depth-to-point block: pixel requests,
// point responses and register writes. Depends on tdp_pkg.
interface tdp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_column;
   logic [11:0] pixel_row;
   logic [15:0] distance;
   logic [15:0] confidence;
   logic [15:0] intensity;
   modport source (output valid, pixel_column, pixel_row, distance, confidence, intensity,
                   input ready);
   modport sink (input valid, pixel_column, pixel_row, distance, confidence, intensity,
                 output ready);
endinterface

interface tdp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] point_x;
   logic signed [20:0] point_y;
   logic signed [20:0] point_z;
   logic               point_valid;
   logic [15:0]        confidence_out;
   logic [15:0]        intensity_out;
   modport source (output valid, point_x, point_y, point_z, point_valid, confidence_out,
                   intensity_out, input ready);
   modport sink (input valid, point_x, point_y, point_z, point_valid, confidence_out,
                 intensity_out, output ready);
endinterface

interface tdp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tdp_pkg::CSR_IDX_W-1:0]   index;
   logic [tdp_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tof_depth_to_point.sv =====
// Top level of the depth-to-point block: register file, normalization and
// distortion stages, and output stage. Depends on tdp_pkg, tdp_if, tdp_div, tdp_sqrt.
//
// Each request beat is one depth pixel (column, row, distance in mm,
// confidence, intensity); each response beat is one point in 1/16 mm with a
// valid flag and the copied confidence and intensity. Every request gives
// exactly one response, in order.
// The pixel is normalized by a 26-stage divider per axis, distorted in a
// chain of multiply and round stages, and divided by the ray length from a
// 32-stage square root and a 22-stage divider per coordinate.
// The path holds 99 register stages, and one beat is accepted in every cycle
// in which no waiting response stalls the pipeline.
// The pipeline advances as a whole: while a response waits and rsp ready is
// low, every stage holds and req ready is low; nothing is lost or repeated.
// Reset empties the pipeline and loads the register reset values. Register
// writes are always taken and are meant to happen while the pipeline is empty.
// Distances of 0 and 0xFFFF give zero coordinates with point_valid low.
module tof_depth_to_point (
   input logic      clock,
   input logic      reset,
   tdp_req_if.sink  req_bus,
   tdp_rsp_if.source rsp_bus,
   tdp_csr_if.sink  csr_bus
);

   typedef struct packed {
      logic [24:0] xm;
      logic        xn;
      logic [24:0] ym;
      logic        yn;
   } nrm_type;

   typedef struct packed {
      tdp_pkg::pass_type pass;
      logic [47:0]       xdd;
      logic              xs;
      logic [47:0]       ydd;
      logic              ys;
   } sq_side_type;

   localparam int MID_N = 14;

   logic        en;
   logic [19:0] center_x_ff, center_y_ff;
   logic [21:0] focal_x_ff, focal_y_ff;
   logic signed [23:0] radial_k1_ff, radial_k2_ff;
   logic signed [15:0] lens_offset_ff;

   assign en            = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = en;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= tdp_pkg::CENTER_X_RST;
         center_y_ff    <= tdp_pkg::CENTER_Y_RST;
         focal_x_ff     <= tdp_pkg::FOCAL_X_RST;
         focal_y_ff     <= tdp_pkg::FOCAL_Y_RST;
         radial_k1_ff   <= '0;
         radial_k2_ff   <= '0;
         lens_offset_ff <= '0;
      end else if (csr_bus.valid) begin
         case (tdp_pkg::csr_idx_type'(csr_bus.index))
            tdp_pkg::CSR_CENTER_X:    center_x_ff    <= csr_bus.data[19:0];
            tdp_pkg::CSR_CENTER_Y:    center_y_ff    <= csr_bus.data[19:0];
            tdp_pkg::CSR_FOCAL_X:     focal_x_ff     <= csr_bus.data[21:0];
            tdp_pkg::CSR_FOCAL_Y:     focal_y_ff     <= csr_bus.data[21:0];
            tdp_pkg::CSR_RADIAL_K1:   radial_k1_ff   <= $signed(csr_bus.data);
            tdp_pkg::CSR_RADIAL_K2:   radial_k2_ff   <= $signed(csr_bus.data);
            tdp_pkg::CSR_LENS_OFFSET: lens_offset_ff <= $signed(csr_bus.data[15:0]);
            default: ;
         endcase
      end
   end

   // Input, offset and numerator stages.
   logic              s0_v_ff, s1_v_ff, s2_v_ff;
   logic [11:0]       s0_col_ff, s0_row_ff;
   tdp_pkg::pass_type s0_pass_ff, s1_pass_ff, s2_pass_ff;
   logic [20:0]       s1_dxm_ff, s1_dym_ff;
   logic              s1_dxn_ff, s1_dyn_ff, s2_dxn_ff, s2_dyn_ff;
   logic [21:0]       s1_fx_ff, s1_fy_ff, s2_fx_ff, s2_fy_ff;
   logic [40:0]       s2_numx_ff, s2_numy_ff;
   logic signed [20:0] dx_in, dy_in;

   assign dx_in = $signed({1'b0, center_x_ff}) - $signed({1'b0, s0_col_ff, 8'h00});
   assign dy_in = $signed({1'b0, center_y_ff}) - $signed({1'b0, s0_row_ff, 8'h00});

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_bus.valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_col_ff             <= req_bus.pixel_column;
         s0_row_ff             <= req_bus.pixel_row;
         s0_pass_ff.confidence <= req_bus.confidence;
         s0_pass_ff.intensity  <= req_bus.intensity;
         s0_pass_ff.distance   <= req_bus.distance;
         s0_pass_ff.dist_ok    <= (req_bus.distance != '0) &&
                                  (req_bus.distance != tdp_pkg::DIST_INVALID);
         s1_dxn_ff  <= dx_in[20];
         s1_dyn_ff  <= dy_in[20];
         s1_dxm_ff  <= dx_in[20] ? 21'(-dx_in) : 21'(dx_in);
         s1_dym_ff  <= dy_in[20] ? 21'(-dy_in) : 21'(dy_in);
         s1_fx_ff   <= (focal_x_ff < tdp_pkg::FOCAL_MIN) ? tdp_pkg::FOCAL_MIN : focal_x_ff;
         s1_fy_ff   <= (focal_y_ff < tdp_pkg::FOCAL_MIN) ? tdp_pkg::FOCAL_MIN : focal_y_ff;
         s1_pass_ff <= s0_pass_ff;
         s2_numx_ff <= {s1_dxm_ff, 20'h00000} + 41'(s1_fx_ff >> 1);
         s2_numy_ff <= {s1_dym_ff, 20'h00000} + 41'(s1_fy_ff >> 1);
         s2_fx_ff   <= s1_fx_ff;
         s2_fy_ff   <= s1_fy_ff;
         s2_dxn_ff  <= s1_dxn_ff;
         s2_dyn_ff  <= s1_dyn_ff;
         s2_pass_ff <= s1_pass_ff;
      end
   end

   logic                       nx_v, nx_ovf, ny_ovf;
   logic [24:0]                nx_q, ny_q;
   logic [tdp_pkg::PASS_W:0]   nx_side;
   logic                       ny_side;

   tdp_div #(.NUM_W(41), .DEN_W(22), .QW(25), .SIDE_W(tdp_pkg::PASS_W + 1)) u_norm_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(s2_v_ff),
      .num(s2_numx_ff), .den(s2_fx_ff), .side_in({s2_pass_ff, s2_dxn_ff}),
      .out_valid(nx_v), .quo(nx_q), .ovf(nx_ovf), .side_out(nx_side)
   );

   tdp_div #(.NUM_W(41), .DEN_W(22), .QW(25), .SIDE_W(1)) u_norm_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(s2_v_ff),
      .num(s2_numy_ff), .den(s2_fy_ff), .side_in(s2_dyn_ff),
      .out_valid(), .quo(ny_q), .ovf(ny_ovf), .side_out(ny_side)
   );

   // Distortion stages.
   logic [MID_N:1]     mid_v_ff;
   tdp_pkg::pass_type  mid_pass_ff [1:MID_N];
   nrm_type            mid_nrm_ff  [1:10];
   nrm_type            nrm_in;
   logic [49:0]        p2_sqx_ff, p2_sqy_ff;
   logic [29:0]        p3_r2_ff;
   logic [59:0]        p4_r2sq_ff;
   logic signed [54:0] p4_k1r2_ff, p5_k1r2_ff, p6_k1r2_ff;
   logic [38:0]        p5_r4_ff;
   logic signed [44:0] p6_k2lo_ff;
   logic signed [43:0] p6_k2hi_ff;
   logic signed [63:0] p7_t_ff, p7_u_ff, p8_sum_ff;
   logic [63:0]        p9_kabs_ff;
   logic               p9_kn_ff, p10_kn_ff;
   logic [28:0]        p10_km_ff;
   logic [53:0]        p11_px_ff, p11_py_ff;
   logic               p11_xs_ff, p11_ys_ff, p12_xs_ff, p12_ys_ff, p13_xs_ff, p13_ys_ff;
   logic [31:0]        p12_xm_ff, p12_ym_ff;
   logic [63:0]        p13_sqx_ff, p13_sqy_ff, p14_rad_ff;
   logic [47:0]        p13_xdd_ff, p13_ydd_ff;
   sq_side_type        p14_side_ff;
   logic [50:0]        r2_sum;
   logic [63:0]        kr;
   logic [54:0]        xr, yr;

   assign nrm_in.xm = (nx_ovf || nx_q > 25'h1000000) ? 25'h1000000 : nx_q;
   assign nrm_in.xn = nx_side[0];
   assign nrm_in.ym = (ny_ovf || ny_q > 25'h1000000) ? 25'h1000000 : ny_q;
   assign nrm_in.yn = ny_side;

   assign r2_sum = 51'(p2_sqx_ff) + 51'(p2_sqy_ff) + 51'(20'h80000);
   assign kr     = (p9_kabs_ff + 64'h80000) >> 20;
   assign xr     = (55'(p11_px_ff) + 55'h80000) >> 20;
   assign yr     = (55'(p11_py_ff) + 55'h80000) >> 20;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_v_ff <= '0;
      end else if (en) begin
         mid_v_ff <= {mid_v_ff[MID_N-1:1], nx_v};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_pass_ff[1] <= tdp_pkg::pass_type'(nx_side[tdp_pkg::PASS_W:1]);
         for (int i = 2; i <= MID_N; i++) begin
            mid_pass_ff[i] <= mid_pass_ff[i-1];
         end
         mid_nrm_ff[1] <= nrm_in;
         for (int i = 2; i <= 10; i++) begin
            mid_nrm_ff[i] <= mid_nrm_ff[i-1];
         end
         p2_sqx_ff  <= mid_nrm_ff[1].xm * mid_nrm_ff[1].xm;
         p2_sqy_ff  <= mid_nrm_ff[1].ym * mid_nrm_ff[1].ym;
         p3_r2_ff   <= r2_sum[49:20];
         p4_r2sq_ff <= p3_r2_ff * p3_r2_ff;
         p4_k1r2_ff <= radial_k1_ff * $signed({1'b0, p3_r2_ff});
         p5_r4_ff   <= 39'((p4_r2sq_ff + 60'h80000) >> 20);
         p5_k1r2_ff <= p4_k1r2_ff;
         p6_k2lo_ff <= radial_k2_ff * $signed({1'b0, p5_r4_ff[19:0]});
         p6_k2hi_ff <= radial_k2_ff * $signed({1'b0, p5_r4_ff[38:20]});
         p6_k1r2_ff <= p5_k1r2_ff;
         p7_t_ff    <= (64'(p6_k2hi_ff) <<< 20) + 64'(p6_k2lo_ff);
         p7_u_ff    <= 64'sh100_0000_0000 + 64'(p6_k1r2_ff);
         p8_sum_ff  <= p7_t_ff + p7_u_ff;
         p9_kn_ff   <= p8_sum_ff[63];
         p9_kabs_ff <= p8_sum_ff[63] ? 64'(-p8_sum_ff) : 64'(p8_sum_ff);
         p10_kn_ff  <= p9_kn_ff;
         p10_km_ff  <= (kr > 64'h1000_0000) ? 29'h1000_0000 : kr[28:0];
         p11_px_ff  <= mid_nrm_ff[10].xm * p10_km_ff;
         p11_py_ff  <= mid_nrm_ff[10].ym * p10_km_ff;
         p11_xs_ff  <= mid_nrm_ff[10].xn ^ p10_kn_ff;
         p11_ys_ff  <= mid_nrm_ff[10].yn ^ p10_kn_ff;
         p12_xm_ff  <= (xr > 55'h8000_0000) ? 32'h8000_0000 : xr[31:0];
         p12_ym_ff  <= (yr > 55'h8000_0000) ? 32'h8000_0000 : yr[31:0];
         p12_xs_ff  <= p11_xs_ff;
         p12_ys_ff  <= p11_ys_ff;
         p13_sqx_ff <= p12_xm_ff * p12_xm_ff;
         p13_sqy_ff <= p12_ym_ff * p12_ym_ff;
         p13_xdd_ff <= p12_xm_ff * mid_pass_ff[12].distance;
         p13_ydd_ff <= p12_ym_ff * mid_pass_ff[12].distance;
         p13_xs_ff  <= p12_xs_ff;
         p13_ys_ff  <= p12_ys_ff;
         p14_rad_ff <= p13_sqx_ff + p13_sqy_ff + 64'h100_0000_0000;
         p14_side_ff.pass <= mid_pass_ff[13];
         p14_side_ff.xdd  <= p13_xdd_ff;
         p14_side_ff.xs   <= p13_xs_ff;
         p14_side_ff.ydd  <= p13_ydd_ff;
         p14_side_ff.ys   <= p13_ys_ff;
      end
   end

   // Ray length and coordinate division.
   logic        sq_v;
   logic [31:0] sq_root;
   sq_side_type sq_side;

   tdp_sqrt #(.SIDE_W($bits(sq_side_type))) u_ray_len (
      .clock(clock), .reset(reset), .en(en), .in_valid(mid_v_ff[MID_N]),
      .rad(p14_rad_ff), .side_in(p14_side_ff),
      .out_valid(sq_v), .root(sq_root), .side_out(sq_side)
   );

   logic              q1_v_ff;
   logic [52:0]       q1_nx_ff, q1_ny_ff, q1_nz_ff;
   logic [31:0]       q1_s_ff;
   logic              q1_xs_ff, q1_ys_ff;
   tdp_pkg::pass_type q1_pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_v_ff <= 1'b0;
      end else if (en) begin
         q1_v_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_nx_ff   <= 53'({sq_side.xdd, 4'h0}) + 53'(sq_root >> 1);
         q1_ny_ff   <= 53'({sq_side.ydd, 4'h0}) + 53'(sq_root >> 1);
         q1_nz_ff   <= 53'({sq_side.pass.distance, 24'h000000}) + 53'(sq_root >> 1);
         q1_s_ff    <= sq_root;
         q1_xs_ff   <= sq_side.xs;
         q1_ys_ff   <= sq_side.ys;
         q1_pass_ff <= sq_side.pass;
      end
   end

   logic              cz_v, cx_ovf, cy_ovf, cz_ovf, cx_side, cy_side;
   logic [20:0]       cx_q, cy_q, cz_q;
   tdp_pkg::pass_type cz_side;

   tdp_div #(.NUM_W(53), .DEN_W(32), .QW(21), .SIDE_W(1)) u_coord_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(q1_v_ff),
      .num(q1_nx_ff), .den(q1_s_ff), .side_in(q1_xs_ff),
      .out_valid(), .quo(cx_q), .ovf(cx_ovf), .side_out(cx_side)
   );

   tdp_div #(.NUM_W(53), .DEN_W(32), .QW(21), .SIDE_W(1)) u_coord_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(q1_v_ff),
      .num(q1_ny_ff), .den(q1_s_ff), .side_in(q1_ys_ff),
      .out_valid(), .quo(cy_q), .ovf(cy_ovf), .side_out(cy_side)
   );

   tdp_div #(.NUM_W(53), .DEN_W(32), .QW(21), .SIDE_W(tdp_pkg::PASS_W)) u_coord_z (
      .clock(clock), .reset(reset), .en(en), .in_valid(q1_v_ff),
      .num(q1_nz_ff), .den(q1_s_ff), .side_in(q1_pass_ff),
      .out_valid(cz_v), .quo(cz_q), .ovf(cz_ovf), .side_out(cz_side)
   );

   // Output stage.
   logic               out_v_ff, out_ok_ff;
   logic signed [20:0] out_x_ff, out_y_ff, out_z_ff;
   logic [15:0]        out_conf_ff, out_int_ff;
   logic signed [20:0] out_x_in, out_y_in, out_z_in;
   logic signed [22:0] zq, zd;

   always_comb begin
      if (cx_side) begin
         out_x_in = (cx_ovf || cx_q > 21'h100000) ? 21'sh100000 : $signed(-cx_q);
      end else begin
         out_x_in = (cx_ovf || cx_q > 21'h0FFFFF) ? 21'sh0FFFFF : $signed(cx_q);
      end
      if (cy_side) begin
         out_y_in = (cy_ovf || cy_q > 21'h100000) ? 21'sh100000 : $signed(-cy_q);
      end else begin
         out_y_in = (cy_ovf || cy_q > 21'h0FFFFF) ? 21'sh0FFFFF : $signed(cy_q);
      end
      zq = cz_ovf ? 23'sh200000 : $signed(23'(cz_q));
      zd = zq - 23'(lens_offset_ff);
      if (zd > 23'sh0FFFFF) begin
         out_z_in = 21'sh0FFFFF;
      end else if (zd < -23'sh100000) begin
         out_z_in = 21'sh100000;
      end else begin
         out_z_in = zd[20:0];
      end
      if (!cz_side.dist_ok) begin
         out_x_in = '0;
         out_y_in = '0;
         out_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= cz_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_z_ff    <= out_z_in;
         out_ok_ff   <= cz_side.dist_ok;
         out_conf_ff <= cz_side.confidence;
         out_int_ff  <= cz_side.intensity;
      end
   end

   assign rsp_bus.valid          = out_v_ff;
   assign rsp_bus.point_x        = out_x_ff;
   assign rsp_bus.point_y        = out_y_ff;
   assign rsp_bus.point_z        = out_z_ff;
   assign rsp_bus.point_valid    = out_ok_ff;
   assign rsp_bus.confidence_out = out_conf_ff;
   assign rsp_bus.intensity_out  = out_int_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.point_valid) |->
      (rsp_bus.point_x == '0 && rsp_bus.point_y == '0 && rsp_bus.point_z == '0))
      else $error("invalid point carries nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

   a_offset_write: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.index == tdp_pkg::CSR_LENS_OFFSET) |=>
      (lens_offset_ff == $signed($past(csr_bus.data[15:0]))))
      else $error("lens offset register not loaded");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while the pipeline is stalled");
`endif

endmodule

// ===== hw/rtl/tdp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// and a sideband that travels with each beat. Depends on nothing.
module tdp_div #(
   parameter int NUM_W  = 53,
   parameter int DEN_W  = 32,
   parameter int QW     = 21,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QW-1:0]     quo,
   output logic              ovf,
   output logic [SIDE_W-1:0] side_out
);

   localparam int HI_W = NUM_W - QW;
   localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [QW:0]       v_ff;
   logic [QW:0]       ovf_ff;
   logic [DEN_W-1:0]  rem_ff  [QW+1];
   logic [DEN_W-1:0]  den_ff  [QW];
   logic [QW-1:0]     low_ff  [QW];
   logic [QW-1:0]     q_ff    [QW+1];
   logic [SIDE_W-1:0] side_ff [QW+1];
   logic [CW-1:0]     hi_ext;
   logic [CW-1:0]     den_ext;
   logic              hi_big;

   assign hi_ext  = CW'(num[NUM_W-1:QW]);
   assign den_ext = CW'(den);
   assign hi_big  = hi_ext >= den_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= hi_big ? '0 : DEN_W'(hi_ext);
         ovf_ff[0]  <= hi_big;
         low_ff[0]  <= num[QW-1:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= den;
         side_ff[0] <= side_in;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_stage
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;

      assign trial = {rem_ff[j-1], low_ff[j-1][QW-1]};
      assign diff  = trial - {1'b0, den_ff[j-1]};
      assign take  = trial >= {1'b0, den_ff[j-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_ff[j]    <= {q_ff[j-1][QW-2:0], take};
            ovf_ff[j]  <= ovf_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end

      if (j < QW) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               low_ff[j] <= {low_ff[j-1][QW-2:0], 1'b0};
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign quo       = q_ff[QW];
   assign ovf       = ovf_ff[QW];
   assign side_out  = side_ff[QW];

endmodule

// ===== hw/rtl/tdp_sqrt.sv =====
// Pipelined integer square root of a 64-bit value, one root bit per stage,
// with a sideband that travels with each beat. Depends on nothing.
module tdp_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       rad,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [31:0]       root,
   output logic [SIDE_W-1:0] side_out
);

   logic [31:0]       v_ff;
   logic [33:0]       rem_ff  [31];
   logic [63:0]       rest_ff [31];
   logic [31:0]       root_ff [32];
   logic [SIDE_W-1:0] side_ff [32];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[30:0], in_valid};
      end
   end

   for (genvar j = 0; j < 32; j++) begin : g_stage
      logic [33:0]       prem;
      logic [31:0]       proot;
      logic [63:0]       prest;
      logic [SIDE_W-1:0] pside;
      logic [35:0]       cur;
      logic [35:0]       trial;
      logic [35:0]       diff;
      logic              take;

      if (j == 0) begin : g_first
         assign prem  = '0;
         assign proot = '0;
         assign prest = rad;
         assign pside = side_in;
      end else begin : g_next
         assign prem  = rem_ff[j-1];
         assign proot = root_ff[j-1];
         assign prest = rest_ff[j-1];
         assign pside = side_ff[j-1];
      end

      assign cur   = {prem, prest[63:62]};
      assign trial = 36'({proot, 2'b01});
      assign diff  = cur - trial;
      assign take  = cur >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j] <= {proot[30:0], take};
            side_ff[j] <= pside;
         end
      end

      if (j < 31) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j]  <= take ? diff[33:0] : cur[33:0];
               rest_ff[j] <= {prest[61:0], 2'b00};
            end
         end
      end
   end

   assign out_valid = v_ff[31];
   assign root      = root_ff[31];
   assign side_out  = side_ff[31];

endmodule

// ===== tb/tof_depth_to_point_test.sv =====
// Self-checking testbench of tof_depth_to_point: directed and random pixels,
// several register settings and random stalls on both channels.
// Depends on tdp_pkg, the channel interfaces in tdp_if and the block itself.
module tof_depth_to_point_test;

   localparam logic [tdp_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam longint ONE_Q20 = 64'sd1 << 20;
   localparam longint NORM_LIM = 64'sd16 << 20;
   localparam longint GAIN_LIM = 64'sd256 << 20;
   localparam longint DIST_LIM = 64'sd2048 << 20;
   localparam longint OUT_MAX = 1048575;
   localparam longint OUT_MIN = -1048576;

   typedef struct {
      logic [11:0] column;
      logic [11:0] row;
      logic [15:0] distance;
      logic [15:0] confidence;
      logic [15:0] intensity;
   } pixel_type;

   typedef struct {
      logic signed [20:0] x;
      logic signed [20:0] y;
      logic signed [20:0] z;
      logic               valid;
      logic [15:0]        confidence;
      logic [15:0]        intensity;
   } point_type;

   typedef struct {
      pixel_type pix;
      bit        typed;
      point_type pt;
   } pixel_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tdp_req_if req_bus ();
   tdp_rsp_if rsp_bus ();
   tdp_csr_if csr_bus ();

   tof_depth_to_point u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always #6 clock = ~clock;

   logic [19:0]        cfg_center_x;
   logic [19:0]        cfg_center_y;
   logic [21:0]        cfg_focal_x;
   logic [21:0]        cfg_focal_y;
   logic signed [23:0] cfg_k1;
   logic signed [23:0] cfg_k2;
   logic signed [15:0] cfg_offset;

   point_type point_queue[$];
   int        send_idle = 0;
   int        recv_idle = 0;
   int        hold_req = 0;
   int        hold_seen = 0;
   int        hold_cycles = 0;
   int        fail_count = 0;
   int        pixels_sent = 0;
   int        points_checked = 0;
   int        settings_used = 0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint div_round(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic point_type unproject(pixel_type p);
      point_type r;
      longint fx, fy, dx, dy, xp, yp, k, xd, yd, d;
      longint unsigned r2, r4, s;
      r.confidence = p.confidence;
      r.intensity = p.intensity;
      r.x = '0;
      r.y = '0;
      r.z = '0;
      r.valid = 1'b0;
      if (p.distance == 16'd0 || p.distance == tdp_pkg::DIST_INVALID) return r;
      fx = cfg_focal_x < tdp_pkg::FOCAL_MIN ? 256 : longint'(cfg_focal_x);
      fy = cfg_focal_y < tdp_pkg::FOCAL_MIN ? 256 : longint'(cfg_focal_y);
      d = longint'(p.distance);
      dx = longint'(cfg_center_x) - (longint'(p.column) << 8);
      dy = longint'(cfg_center_y) - (longint'(p.row) << 8);
      xp = clamp(div_round(dx * ONE_Q20, fx), -NORM_LIM, NORM_LIM);
      yp = clamp(div_round(dy * ONE_Q20, fy), -NORM_LIM, NORM_LIM);
      r2 = (longint'(xp * xp) + longint'(yp * yp) + (64'd1 << 19)) >> 20;
      r4 = (r2 * r2 + (64'd1 << 19)) >> 20;
      k = div_round((ONE_Q20 << 20) + longint'(cfg_k1) * longint'(r2)
                    + longint'(cfg_k2) * longint'(r4), ONE_Q20);
      k = clamp(k, -GAIN_LIM, GAIN_LIM);
      xd = clamp(div_round(xp * k, ONE_Q20), -DIST_LIM, DIST_LIM);
      yd = clamp(div_round(yp * k, ONE_Q20), -DIST_LIM, DIST_LIM);
      s = int_sqrt(longint'(unsigned'(xd * xd)) + longint'(unsigned'(yd * yd))
                   + (64'd1 << 40));
      r.x = 21'(clamp(div_round(xd * d * 16, longint'(s)), OUT_MIN, OUT_MAX));
      r.y = 21'(clamp(div_round(yd * d * 16, longint'(s)), OUT_MIN, OUT_MAX));
      r.z = 21'(clamp(div_round(d << 24, longint'(s)) - longint'(cfg_offset),
                      OUT_MIN, OUT_MAX));
      r.valid = 1'b1;
      return r;
   endfunction

   task automatic write_reg(logic [tdp_pkg::CSR_IDX_W-1:0] idx,
                            logic [tdp_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         tdp_pkg::CSR_CENTER_X:    cfg_center_x = value[19:0];
         tdp_pkg::CSR_CENTER_Y:    cfg_center_y = value[19:0];
         tdp_pkg::CSR_FOCAL_X:     cfg_focal_x = value[21:0];
         tdp_pkg::CSR_FOCAL_Y:     cfg_focal_y = value[21:0];
         tdp_pkg::CSR_RADIAL_K1:   cfg_k1 = value;
         tdp_pkg::CSR_RADIAL_K2:   cfg_k2 = value;
         tdp_pkg::CSR_LENS_OFFSET: cfg_offset = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_setting(logic [19:0] cx, logic [19:0] cy, logic [21:0] fx,
                               logic [21:0] fy, logic [23:0] k1, logic [23:0] k2,
                               logic [15:0] offset);
      wait (point_queue.size() == 0);
      repeat (110) @(posedge clock);
      write_reg(tdp_pkg::CSR_CENTER_X, 24'(cx));
      write_reg(tdp_pkg::CSR_CENTER_Y, 24'(cy));
      write_reg(tdp_pkg::CSR_FOCAL_X, 24'(fx));
      write_reg(tdp_pkg::CSR_FOCAL_Y, 24'(fy));
      write_reg(tdp_pkg::CSR_RADIAL_K1, k1);
      write_reg(tdp_pkg::CSR_RADIAL_K2, k2);
      write_reg(tdp_pkg::CSR_LENS_OFFSET, {8'h00, offset});
      settings_used++;
   endtask

   task automatic send_pixel(pixel_type p, bit typed, point_type pt);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_column <= p.column;
      req_bus.pixel_row <= p.row;
      req_bus.distance <= p.distance;
      req_bus.confidence <= p.confidence;
      req_bus.intensity <= p.intensity;
      do @(posedge clock); while (!req_bus.ready);
      point_queue = {point_queue, (typed ? pt : unproject(p))};
      pixels_sent++;
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.column = 12'($urandom);
      p.row = 12'($urandom);
      if ($urandom_range(3) == 0) begin
         p.column = 12'(cfg_center_x >> 8) + 12'($urandom_range(15)) - 12'd8;
         p.row = 12'(cfg_center_y >> 8) + 12'($urandom_range(15)) - 12'd8;
      end
      case ($urandom_range(9))
         0:       p.distance = 16'd0;
         1:       p.distance = tdp_pkg::DIST_INVALID;
         2:       p.distance = 16'($urandom_range(1, 64));
         default: p.distance = 16'($urandom_range(1, 65534));
      endcase
      p.confidence = 16'($urandom);
      p.intensity = 16'($urandom);
      return p;
   endfunction

   task automatic random_burst(int count);
      point_type none;
      none = '{default: '0};
      repeat (count) send_pixel(random_pixel(), 1'b0, none);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         rsp_bus.ready <= 1'b0;
         hold_seen <= hold_req;
         hold_cycles <= 300;
      end else if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= $urandom_range(99) >= recv_idle;
      end
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (point_queue.size() == 0) begin
            $error("response beat with no point expected");
            fail_count++;
         end else begin
            want = point_queue.pop_front();
            points_checked++;
            if (rsp_bus.point_x !== want.x) begin
               $error("point_x expected %0d got %0d", want.x, rsp_bus.point_x);
               fail_count++;
            end
            if (rsp_bus.point_y !== want.y) begin
               $error("point_y expected %0d got %0d", want.y, rsp_bus.point_y);
               fail_count++;
            end
            if (rsp_bus.point_z !== want.z) begin
               $error("point_z expected %0d got %0d", want.z, rsp_bus.point_z);
               fail_count++;
            end
            if (rsp_bus.point_valid !== want.valid) begin
               $error("point_valid expected %0d got %0d", want.valid, rsp_bus.point_valid);
               fail_count++;
            end
            if (rsp_bus.confidence_out !== want.confidence) begin
               $error("confidence_out expected %0h got %0h", want.confidence,
                      rsp_bus.confidence_out);
               fail_count++;
            end
            if (rsp_bus.intensity_out !== want.intensity) begin
               $error("intensity_out expected %0h got %0h", want.intensity,
                      rsp_bus.intensity_out);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #(12 * 600000);
      $display("FAILURE");
      $finish;
   end

   initial begin
      pixel_row_type directed[$];
      point_type     none;
      none = '{default: '0};
      req_bus.valid = 1'b0;
      req_bus.pixel_column = '0;
      req_bus.pixel_row = '0;
      req_bus.distance = '0;
      req_bus.confidence = '0;
      req_bus.intensity = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      cfg_center_x = tdp_pkg::CENTER_X_RST;
      cfg_center_y = tdp_pkg::CENTER_Y_RST;
      cfg_focal_x = tdp_pkg::FOCAL_X_RST;
      cfg_focal_y = tdp_pkg::FOCAL_Y_RST;
      cfg_k1 = '0;
      cfg_k2 = '0;
      cfg_offset = '0;
      send_idle = 27;
      recv_idle = 52;

      // The optical centre of the reset setting is pixel (88, 72).
      directed = '{
         '{'{12'd88, 12'd72, 16'd1000, 16'h1234, 16'h5678}, 1'b1,
           '{21'sd0, 21'sd0, 21'sd16000, 1'b1, 16'h1234, 16'h5678}},
         '{'{12'd88, 12'd72, 16'd1, 16'hFFFF, 16'h0000}, 1'b1,
           '{21'sd0, 21'sd0, 21'sd16, 1'b1, 16'hFFFF, 16'h0000}},
         '{'{12'd88, 12'd72, 16'd65534, 16'h0000, 16'hFFFF}, 1'b1,
           '{21'sd0, 21'sd0, 21'sd1048544, 1'b1, 16'h0000, 16'hFFFF}},
         '{'{12'd0, 12'd0, 16'd0, 16'hAAAA, 16'h5555}, 1'b1,
           '{21'sd0, 21'sd0, 21'sd0, 1'b0, 16'hAAAA, 16'h5555}},
         '{'{12'd4095, 12'd4095, 16'hFFFF, 16'h5555, 16'hAAAA}, 1'b1,
           '{21'sd0, 21'sd0, 21'sd0, 1'b0, 16'h5555, 16'hAAAA}},
         '{'{12'd0, 12'd0, 16'd65534, 16'd1, 16'd2}, 1'b0, none},
         '{'{12'd4095, 12'd4095, 16'd65534, 16'd3, 16'd4}, 1'b0, none},
         '{'{12'd0, 12'd4095, 16'd1, 16'd5, 16'd6}, 1'b0, none},
         '{'{12'd4095, 12'd0, 16'd30000, 16'd7, 16'd8}, 1'b0, none},
         '{'{12'd100, 12'd60, 16'd2500, 16'd9, 16'd10}, 1'b0, none},
         '{'{12'd89, 12'd72, 16'd65534, 16'd11, 16'd12}, 1'b0, none},
         '{'{12'd88, 12'd73, 16'd777, 16'd13, 16'd14}, 1'b0, none}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      foreach (directed[i]) send_pixel(directed[i].pix, directed[i].typed, directed[i].pt);
      req_bus.valid <= 1'b0;

      // A write to an unused index must leave every register alone.
      load_setting(tdp_pkg::CENTER_X_RST, tdp_pkg::CENTER_Y_RST, tdp_pkg::FOCAL_X_RST,
                   tdp_pkg::FOCAL_Y_RST, 24'd0, 24'd0, 16'd0);
      write_reg(CSR_UNUSED_IDX, 24'hFFFFFF);
      random_burst(100);
      req_bus.valid <= 1'b0;

      // Extremes: focal below the minimum, largest centre, strongest distortion.
      load_setting(20'hFFFFF, 20'hFFFFF, 22'd0, 22'd255, 24'h7FFFFF, 24'h7FFFFF,
                   16'h8000);
      random_burst(80);
      req_bus.valid <= 1'b0;

      load_setting(20'd0, 20'd0, 22'h3FFFFF, 22'h3FFFFF, 24'h800000, 24'h800000,
                   16'h7FFF);
      send_idle = 52;
      recv_idle = 27;
      random_burst(80);
      req_bus.valid <= 1'b0;

      load_setting(20'd40000, 20'd30000, 22'd256, 22'd256, 24'hF00000, 24'h080000,
                   16'hFF00);
      random_burst(80);
      req_bus.valid <= 1'b0;

      repeat (3) begin
         load_setting(20'($urandom), 20'($urandom), 22'($urandom_range(256, 4194303)),
                      22'($urandom_range(256, 4194303)), 24'($urandom),
                      24'($urandom_range(0, 4095)), 16'($urandom));
         send_idle = 0;
         recv_idle = 0;
         hold_req++;
         random_burst(120);
         req_bus.valid <= 1'b0;
      end

      wait (point_queue.size() == 0);
      repeat (120) @(posedge clock);
      $display("Sent %0d pixels under %0d register settings, checked %0d points.",
               pixels_sent, settings_used, points_checked);
      $display("Covered invalid distances, focal clamping, saturation and long stalls.");
      if (fail_count == 0 && point_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
